[design/randomized_set_engine_top_defines.svh]
// assertion helpers shared by the block's checks
// both sample on clk and are held off while rst_n is low
`ifndef RANDOMIZED_SET_ENGINE_TOP_DEFINES_SVH
`define RANDOMIZED_SET_ENGINE_TOP_DEFINES_SVH

// same-cycle implication
`define RSE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RSE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/rse_pkg.sv]
`default_nettype none

package rse_pkg;

  // field widths
  localparam int ACT_W    = 2;
  localparam int VALUE_W  = 32;
  localparam int RW_W     = 31;
  localparam int STAT_W   = 2;
  localparam int MCOUNT_W = 7;
  localparam int IN_W     = 72;
  localparam int OUT_W    = 48;

  localparam int CAPACITY_DEF = 64;

  typedef logic [ACT_W-1:0]  act_t;
  typedef logic [STAT_W-1:0] stat_t;

  // action codes
  localparam act_t ACT_INS  = 2'd0;
  localparam act_t ACT_REM  = 2'd1;
  localparam act_t ACT_RAND = 2'd2;

  // status codes
  localparam stat_t ST_DONE  = 2'd0;
  localparam stat_t ST_MISS  = 2'd1;
  localparam stat_t ST_FULL  = 2'd2;
  localparam stat_t ST_EMPTY = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic  start;      // latch beat, clear search and divider
    logic  scan_en;    // issue next search read
    logic  latch_hit;  // remember matching slot
    logic  ins_wr;     // append value, count up
    logic  rd_last;    // read last live entry
    logic  wr_moved;   // move last entry into hole, count down
    logic  div_en;     // one divider step
    logic  rd_rand;    // read chosen slot
    logic  cap_rand;   // capture chosen member
    logic  load_res;   // load output register
    stat_t res_status;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    act_t new_act;
    act_t act;
    logic cnt_zero;
    logic cnt_full;
    logic scan_hit;
    logic scan_last;
    logic found;
    logic div_last;
  } sts_t;

endpackage

`default_nettype wire

[design/randomized_set_engine_top.sv]
// channel   | direction | tdata (low bit up)                                 | tuser | tlast
// in_       | slave     | action[1:0] value[33:2] random_word[64:34] pad     | none  | none
// out_      | master    | status[1:0] member_value[33:2] member_count[40:34] | none  | none
//
// one item at a time; a result waits in the output register while the next beat is taken
// insert/remove: the one-slot-per-cycle search over the live entries sets the time per beat
// random member: the modulo comes from the 31-step restoring divider, and the result
//   follows once the chosen slot has been read
// rst_n (synchronous) clears the count; the store needs no clearing pass
// a stalled result holds the next result back in the response state until out_tready
`default_nettype none

`include "randomized_set_engine_top_defines.svh"

module randomized_set_engine_top #(
  parameter int CAPACITY = rse_pkg::CAPACITY_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_tvalid,
  output logic                           in_tready,
  // action[1:0], value[33:2], random_word[64:34], zeros[71:65]
  input  wire logic [rse_pkg::IN_W-1:0]  in_tdata,
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  // status[1:0], member_value[33:2], member_count[40:34], zeros[47:41]
  output logic [rse_pkg::OUT_W-1:0]      out_tdata
);

  import rse_pkg::*;

  cmd_t cmd;
  sts_t sts;

  stat_t              res_status;
  logic [VALUE_W-1:0] res_member;
  logic [MCOUNT_W-1:0] res_count;
  logic               res_fail;

  // sequencer
  rse_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // store, search, divider and result register
  rse_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_tdata (out_tdata)
  );

  // result fields for the checks
  assign res_status = out_tdata[1:0];
  assign res_member = out_tdata[33:2];
  assign res_count  = out_tdata[40:34];
  assign res_fail   = out_tvalid && (res_status != ST_DONE);

  // checks
  `RSE_ASSERT_IMP(a_no_append_full, cmd.ins_wr, !sts.cnt_full, "append into a full store")
  `RSE_ASSERT_IMP(a_count_range, out_tvalid, (32'(res_count) <= CAPACITY), "count over capacity")
  `RSE_ASSERT_IMP(a_zero_member, res_fail, (res_member == '0), "member set on failure")
  `RSE_ASSERT_NXT(a_load_valid, cmd.load_res, out_tvalid, "loaded result not shown")

endmodule

`default_nettype wire

[design/rse_ram.sv]
`default_nettype none

module rse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[design/rse_datapath.sv]
`default_nettype none

module rse_datapath #(
  parameter int CAPACITY = rse_pkg::CAPACITY_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic [rse_pkg::IN_W-1:0] in_tdata,
  input  wire rse_pkg::cmd_t            cmd,
  output rse_pkg::sts_t                 sts,
  output logic [rse_pkg::OUT_W-1:0]     out_tdata
);

  import rse_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);
  localparam logic [4:0]       DIV_LAST = 5'(RW_W - 1);

  // beat fields
  act_t               in_act;
  logic [VALUE_W-1:0] in_value;
  logic [RW_W-1:0]    in_rw;

  assign in_act   = in_tdata[1:0];
  assign in_value = in_tdata[33:2];
  assign in_rw    = in_tdata[64:34];

  // registers
  logic [CNT_W-1:0]   count_r,    count_nxt;
  act_t               act_r,      act_nxt;
  logic [VALUE_W-1:0] value_r,    value_nxt;
  logic [CNT_W-1:0]   scan_idx_r, scan_idx_nxt;
  logic [CNT_W-1:0]   cmp_pos_r,  cmp_pos_nxt;
  logic               cmp_vld_r,  cmp_vld_nxt;
  logic               found_r,    found_nxt;
  logic [IDX_W-1:0]   hit_pos_r,  hit_pos_nxt;
  logic [RW_W-1:0]    dvd_r,      dvd_nxt;
  logic [CNT_W-1:0]   rem_r,      rem_nxt;
  logic [4:0]         div_cnt_r,  div_cnt_nxt;
  logic [VALUE_W-1:0] member_r,   member_nxt;
  logic [OUT_W-1:0]   out_r,      out_nxt;

  // memory port signals
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [VALUE_W-1:0] ram_wdata;
  logic [IDX_W-1:0]   ram_raddr;
  logic [VALUE_W-1:0] ram_rdata;

  logic [CNT_W-1:0]   last_idx;
  logic [CNT_W:0]     trial;
  logic [31:0]        cnt_wide;

  assign last_idx = count_r - ONE_CNT;
  assign trial    = {rem_r, dvd_r[RW_W-1]};
  assign cnt_wide = 32'(count_r);

  rse_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // read address select
  always_comb begin
    priority if (cmd.rd_last) begin
      ram_raddr = last_idx[IDX_W-1:0];
    end else if (cmd.rd_rand) begin
      ram_raddr = rem_r[IDX_W-1:0];
    end else begin
      ram_raddr = scan_idx_r[IDX_W-1:0];
    end
  end

  // write port: append or fill the hole
  always_comb begin
    ram_we    = cmd.ins_wr || cmd.wr_moved;
    ram_waddr = cmd.wr_moved ? hit_pos_r : count_r[IDX_W-1:0];
    ram_wdata = cmd.wr_moved ? ram_rdata : value_r;
  end

  // status to controller
  always_comb begin
    sts.new_act   = in_act;
    sts.act       = act_r;
    sts.cnt_zero  = (count_r == '0);
    sts.cnt_full  = (count_r >= CAP_CNT);
    sts.scan_hit  = cmp_vld_r && (ram_rdata == value_r);
    sts.scan_last = cmp_vld_r && (cmp_pos_r == last_idx);
    sts.found     = found_r;
    sts.div_last  = (div_cnt_r == DIV_LAST);
  end

  // next state
  always_comb begin
    count_nxt    = count_r;
    act_nxt      = act_r;
    value_nxt    = value_r;
    scan_idx_nxt = scan_idx_r;
    cmp_pos_nxt  = cmp_pos_r;
    cmp_vld_nxt  = 1'b0;
    found_nxt    = found_r;
    hit_pos_nxt  = hit_pos_r;
    dvd_nxt      = dvd_r;
    rem_nxt      = rem_r;
    div_cnt_nxt  = div_cnt_r;
    member_nxt   = member_r;
    out_nxt      = out_r;

    // beat capture
    if (cmd.start) begin
      act_nxt      = in_act;
      value_nxt    = in_value;
      scan_idx_nxt = '0;
      found_nxt    = 1'b0;
      dvd_nxt      = in_rw;
      rem_nxt      = '0;
      div_cnt_nxt  = '0;
      member_nxt   = '0;
    end

    // pipelined search: read one slot, compare it once the registered read data returns
    if (cmd.scan_en && (scan_idx_r < count_r)) begin
      cmp_vld_nxt  = 1'b1;
      cmp_pos_nxt  = scan_idx_r;
      scan_idx_nxt = scan_idx_r + ONE_CNT;
    end
    if (cmd.latch_hit) begin
      found_nxt   = 1'b1;
      hit_pos_nxt = cmp_pos_r[IDX_W-1:0];
    end

    // restoring divider, one quotient bit per step
    if (cmd.div_en) begin
      if (trial >= {1'b0, count_r}) begin
        rem_nxt = CNT_W'(trial - {1'b0, count_r});
      end else begin
        rem_nxt = trial[CNT_W-1:0];
      end
      dvd_nxt     = {dvd_r[RW_W-2:0], 1'b0};
      div_cnt_nxt = div_cnt_r + 5'd1;
    end

    if (cmd.cap_rand) begin
      member_nxt = ram_rdata;
    end

    // member count update
    if (cmd.ins_wr) begin
      count_nxt = count_r + ONE_CNT;
    end else if (cmd.wr_moved) begin
      count_nxt = last_idx;
    end

    // output register
    if (cmd.load_res) begin
      out_nxt = {7'b0, cnt_wide[MCOUNT_W-1:0], member_r, cmd.res_status};
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      cmp_vld_r <= 1'b0;
      found_r   <= 1'b0;
      div_cnt_r <= '0;
    end else begin
      count_r   <= count_nxt;
      cmp_vld_r <= cmp_vld_nxt;
      found_r   <= found_nxt;
      div_cnt_r <= div_cnt_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    act_r      <= act_nxt;
    value_r    <= value_nxt;
    scan_idx_r <= scan_idx_nxt;
    cmp_pos_r  <= cmp_pos_nxt;
    hit_pos_r  <= hit_pos_nxt;
    dvd_r      <= dvd_nxt;
    rem_r      <= rem_nxt;
    member_r   <= member_nxt;
    out_r      <= out_nxt;
  end

  assign out_tdata = out_r;

endmodule

`default_nettype wire

[design/rse_ctrl.sv]
`default_nettype none

module rse_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  input  wire rse_pkg::sts_t sts,
  output rse_pkg::cmd_t      cmd
);

  import rse_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SCAN   = 4'd1;
  localparam logic [3:0] S_DECIDE = 4'd2;
  localparam logic [3:0] S_WRLAST = 4'd3;
  localparam logic [3:0] S_DIV    = 4'd4;
  localparam logic [3:0] S_RDRAND = 4'd5;
  localparam logic [3:0] S_RDWAIT = 4'd6;
  localparam logic [3:0] S_RESP   = 4'd7;

  logic [3:0] state_r,  state_nxt;
  stat_t      status_r, status_nxt;
  logic       ovld_r,   ovld_nxt;
  logic       res_free;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ovld_r;
  assign res_free   = !ovld_r || out_tready;

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    status_nxt     = status_r;
    cmd            = '0;
    cmd.res_status = status_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.start = 1'b1;
          if (sts.new_act == ACT_INS || sts.new_act == ACT_REM) begin
            state_nxt = sts.cnt_zero ? S_DECIDE : S_SCAN;
          end else if (sts.new_act == ACT_RAND) begin
            if (sts.cnt_zero) begin
              status_nxt = ST_EMPTY;
              state_nxt  = S_RESP;
            end else begin
              state_nxt = S_DIV;
            end
          end else begin
            // unused code: no change, plain done
            status_nxt = ST_DONE;
            state_nxt  = S_RESP;
          end
        end
      end
      S_SCAN: begin
        cmd.scan_en = 1'b1;
        if (sts.scan_hit) begin
          cmd.latch_hit = 1'b1;
          state_nxt     = S_DECIDE;
        end else if (sts.scan_last) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts.act == ACT_INS) begin
          state_nxt = S_RESP;
          if (sts.found) begin
            status_nxt = ST_MISS;
          end else if (sts.cnt_full) begin
            status_nxt = ST_FULL;
          end else begin
            cmd.ins_wr = 1'b1;
            status_nxt = ST_DONE;
          end
        end else if (!sts.found) begin
          status_nxt = ST_MISS;
          state_nxt  = S_RESP;
        end else begin
          cmd.rd_last = 1'b1;
          state_nxt   = S_WRLAST;
        end
      end
      S_WRLAST: begin
        cmd.wr_moved = 1'b1;
        status_nxt   = ST_DONE;
        state_nxt    = S_RESP;
      end
      S_DIV: begin
        cmd.div_en = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_RDRAND;
        end
      end
      S_RDRAND: begin
        cmd.rd_rand = 1'b1;
        state_nxt   = S_RDWAIT;
      end
      S_RDWAIT: begin
        cmd.cap_rand = 1'b1;
        status_nxt   = ST_DONE;
        state_nxt    = S_RESP;
      end
      S_RESP: begin
        if (res_free) begin
          cmd.load_res = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output valid flag
  always_comb begin
    ovld_nxt = ovld_r;
    if (cmd.load_res) begin
      ovld_nxt = 1'b1;
    end else if (out_tready) begin
      ovld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      status_r <= ST_DONE;
      ovld_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      status_r <= status_nxt;
      ovld_r   <= ovld_nxt;
    end
  end

endmodule

`default_nettype wire
